FILE: design/drt_pkg.sv
// Shared types and constants for the dedup record table.
package drt_pkg;

   localparam int SLOTS_DEF = 16;
   localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

   localparam logic [2:0] ACT_LOOKUP   = 3'd0;
   localparam logic [2:0] ACT_CLAIM    = 3'd1;
   localparam logic [2:0] ACT_FINALIZE = 3'd2;
   localparam logic [2:0] ACT_RELEASE  = 3'd3;
   localparam logic [2:0] ACT_CLEAR    = 3'd4;
   localparam logic [2:0] ACT_COUNT    = 3'd5;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STS_BAD_STATE = 3'd2;
   localparam logic [2:0] STS_NO_SPACE  = 3'd3;
   localparam logic [2:0] STS_BAD_ARG   = 3'd4;

   localparam logic [1:0] KIND_MISS     = 2'd0;
   localparam logic [1:0] KIND_REPLAY   = 2'd1;
   localparam logic [1:0] KIND_CONFLICT = 2'd2;

   typedef struct packed {
      logic [255:0] key;
      logic [255:0] req;
      logic [31:0]  seq;
   } rec_type;

   typedef struct packed {
      logic        rec_en;
      logic        id_en;
      rec_type     rec;
      logic [31:0] id;
   } wr_type;

endpackage

FILE: design/drt_if.sv
// Request and response channel interfaces.
interface drt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [63:0] key_hash_0;
   logic [63:0] key_hash_1;
   logic [63:0] key_hash_2;
   logic [63:0] key_hash_3;
   logic [63:0] request_hash_0;
   logic [63:0] request_hash_1;
   logic [63:0] request_hash_2;
   logic [63:0] request_hash_3;
   logic [31:0] new_message_id;
   modport source (output valid, action, key_hash_0, key_hash_1, key_hash_2, key_hash_3,
                   request_hash_0, request_hash_1, request_hash_2, request_hash_3,
                   new_message_id, input ready);
   modport sink (input valid, action, key_hash_0, key_hash_1, key_hash_2, key_hash_3,
                 request_hash_0, request_hash_1, request_hash_2, request_hash_3,
                 new_message_id, output ready);
endinterface

interface drt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  match_kind;
   logic [31:0] found_message_id;
   logic [4:0]  free_count;
   logic [4:0]  pending_count;
   logic [4:0]  finalized_count;
   logic [4:0]  cleared_count;
   modport source (output valid, status, match_kind, found_message_id, free_count,
                   pending_count, finalized_count, cleared_count, input ready);
   modport sink (input valid, status, match_kind, found_message_id, free_count,
                 pending_count, finalized_count, cleared_count, output ready);
endinterface

FILE: design/dedup_record_table.sv
// Dedup record table: each accepted request word yields one result word; every
// action scans all slots through the record memory read port, one slot per cycle,
// then commits and presents the result word.
// The next request word is taken only after the result word is delivered.
// Synchronous reset marks every slot empty; memory contents need no clearing.
module dedup_record_table #(
   parameter int SLOTS = drt_pkg::SLOTS_DEF
) (
   input logic      clock,
   input logic      reset,
   drt_req_if.sink  req,
   drt_rsp_if.source rsp
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_RESP} state_type;

   state_type   state_ff, state_in;
   logic [2:0]  act_ff, act_in;
   logic [255:0] key_ff, key_in, rqh_ff, rqh_in;
   logic [31:0] nid_ff, nid_in;
   logic [IW-1:0] scan_ff, scan_in, eidx_ff, eidx_in;
   logic        issue_ff, issue_in, eval_ff, eval_in;
   logic        hit_ff, hit_in, hreq_ff, hreq_in;
   logic [IW-1:0] hidx_ff, hidx_in, emp_idx_ff, emp_idx_in, old_idx_ff, old_idx_in;
   logic [31:0] hid_ff, hid_in, old_seq_ff, old_seq_in, max_ff, max_in;
   logic        emp_ff, emp_in, old_ff, old_in;
   logic [4:0]  free_ff, free_in, pend_ff, pend_in, fin_ff, fin_in, clr_ff, clr_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic        rv_ff, rv_in;
   logic [2:0]  sts_ff, sts_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] fid_ff, fid_in;

   drt_pkg::rec_type rd_rec;
   logic [31:0]      rd_id;
   drt_pkg::wr_type  wr;
   logic [IW-1:0]    wr_addr;

   logic v, keq, qeq, idz, room;
   logic [IW-1:0] slot_c;

   drt_store #(.SLOTS(SLOTS)) u_store (
      .clock   (clock),
      .rd_addr (scan_ff),
      .rd_rec  (rd_rec),
      .rd_id   (rd_id),
      .wr_addr (wr_addr),
      .wr      (wr)
   );

   assign req.ready            = (state_ff == S_IDLE);
   assign rsp.valid            = rv_ff;
   assign rsp.status           = sts_ff;
   assign rsp.match_kind       = kind_ff;
   assign rsp.found_message_id = fid_ff;
   assign rsp.free_count       = free_ff;
   assign rsp.pending_count    = pend_ff;
   assign rsp.finalized_count  = fin_ff;
   assign rsp.cleared_count    = clr_ff;

   assign v    = valid_ff[eidx_ff];
   assign keq  = (rd_rec.key == key_ff);
   assign qeq  = (rd_rec.req == rqh_ff);
   assign idz  = (rd_id == 32'd0);
   assign room = emp_ff || old_ff;
   assign slot_c = emp_ff ? emp_idx_ff : old_idx_ff;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff; key_in = key_ff; rqh_in = rqh_ff; nid_in = nid_ff;
      scan_in = scan_ff; eidx_in = eidx_ff; issue_in = issue_ff; eval_in = 1'b0;
      hit_in = hit_ff; hreq_in = hreq_ff; hidx_in = hidx_ff; hid_in = hid_ff;
      emp_in = emp_ff; emp_idx_in = emp_idx_ff;
      old_in = old_ff; old_idx_in = old_idx_ff; old_seq_in = old_seq_ff;
      max_in = max_ff;
      free_in = free_ff; pend_in = pend_ff; fin_in = fin_ff; clr_in = clr_ff;
      valid_in = valid_ff;
      rv_in = rv_ff; sts_in = sts_ff; kind_in = kind_ff; fid_in = fid_ff;
      wr = '0;
      wr.rec.key = key_ff;
      wr.rec.req = rqh_ff;
      wr.rec.seq = (max_ff == drt_pkg::SEQ_MAX) ? 32'd1 : max_ff + 32'd1;
      wr_addr = hidx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               act_in = req.action;
               key_in = {req.key_hash_3, req.key_hash_2, req.key_hash_1, req.key_hash_0};
               rqh_in = {req.request_hash_3, req.request_hash_2,
                         req.request_hash_1, req.request_hash_0};
               nid_in = req.new_message_id;
               scan_in = '0; issue_in = 1'b1;
               hit_in = 1'b0; emp_in = 1'b0; old_in = 1'b0;
               old_seq_in = drt_pkg::SEQ_MAX; max_in = '0;
               free_in = '0; pend_in = '0; fin_in = '0; clr_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one slot read per cycle; read data returns in the next cycle
            if (issue_ff) begin
               eval_in = 1'b1;
               eidx_in = scan_ff;
               if (scan_ff == LAST) begin
                  issue_in = 1'b0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            if (eval_ff) begin
               if (v && keq && !hit_ff) begin
                  hit_in = 1'b1; hidx_in = eidx_ff; hreq_in = qeq; hid_in = rd_id;
               end
               if (!v) begin
                  free_in = free_ff + 5'd1;
                  if (!emp_ff) begin
                     emp_in = 1'b1; emp_idx_in = eidx_ff;
                  end
               end else begin
                  if (rd_rec.seq > max_ff) max_in = rd_rec.seq;
                  if (!idz && rd_rec.seq < old_seq_ff) begin
                     old_in = 1'b1; old_idx_in = eidx_ff; old_seq_in = rd_rec.seq;
                  end
                  if (idz) pend_in = pend_ff + 5'd1;
                  else fin_in = fin_ff + 5'd1;
                  if (idz && act_ff == drt_pkg::ACT_CLEAR) begin
                     valid_in[eidx_ff] = 1'b0;
                     clr_in = clr_ff + 5'd1;
                  end
               end
               if (eidx_ff == LAST) state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            sts_in = drt_pkg::STS_OK; kind_in = drt_pkg::KIND_MISS; fid_in = '0;
            if (act_ff != drt_pkg::ACT_COUNT) begin
               free_in = '0; pend_in = '0; fin_in = '0;
            end
            if (act_ff != drt_pkg::ACT_CLEAR) clr_in = '0;
            case (act_ff)
               drt_pkg::ACT_LOOKUP, drt_pkg::ACT_CLAIM: begin
                  if (hit_ff) begin
                     fid_in = hid_ff;
                     kind_in = hreq_ff ? drt_pkg::KIND_REPLAY : drt_pkg::KIND_CONFLICT;
                  end else if (act_ff == drt_pkg::ACT_CLAIM) begin
                     if (!room) begin
                        sts_in = drt_pkg::STS_NO_SPACE;
                     end else begin
                        wr_addr = slot_c;
                        wr.rec_en = 1'b1;
                        wr.id_en = 1'b1;
                        valid_in[slot_c] = 1'b1;
                     end
                  end
               end
               drt_pkg::ACT_FINALIZE: begin
                  if (nid_ff == 32'd0) sts_in = drt_pkg::STS_BAD_ARG;
                  else if (!hit_ff) sts_in = drt_pkg::STS_NOT_FOUND;
                  else if (!hreq_ff) sts_in = drt_pkg::STS_BAD_STATE;
                  else begin
                     wr.id_en = 1'b1;
                     wr.id = nid_ff;
                  end
               end
               drt_pkg::ACT_RELEASE: begin
                  if (!hit_ff) sts_in = drt_pkg::STS_NOT_FOUND;
                  else if (!hreq_ff || hid_ff != 32'd0) sts_in = drt_pkg::STS_BAD_STATE;
                  else valid_in[hidx_ff] = 1'b0;
               end
               drt_pkg::ACT_CLEAR, drt_pkg::ACT_COUNT: begin
                  sts_in = drt_pkg::STS_OK;
               end
               default: begin
                  sts_in = drt_pkg::STS_BAD_ARG;
               end
            endcase
            rv_in = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) begin
               rv_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rv_ff    <= 1'b0;
         issue_ff <= 1'b0;
         eval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rv_ff    <= rv_in;
         issue_ff <= issue_in;
         eval_ff  <= eval_in;
      end
      act_ff <= act_in; key_ff <= key_in; rqh_ff <= rqh_in; nid_ff <= nid_in;
      scan_ff <= scan_in; eidx_ff <= eidx_in;
      hit_ff <= hit_in; hreq_ff <= hreq_in; hidx_ff <= hidx_in; hid_ff <= hid_in;
      emp_ff <= emp_in; emp_idx_ff <= emp_idx_in;
      old_ff <= old_in; old_idx_ff <= old_idx_in; old_seq_ff <= old_seq_in;
      max_ff <= max_in;
      free_ff <= free_in; pend_ff <= pend_in; fin_ff <= fin_in; clr_ff <= clr_in;
      sts_ff <= sts_in; kind_ff <= kind_in; fid_ff <= fid_in;
   end

endmodule

FILE: design/drt_store.sv
// Slot record and message id memories with a registered read port.
module drt_store #(
   parameter int SLOTS = drt_pkg::SLOTS_DEF
) (
   input  logic                                    clock,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   output drt_pkg::rec_type                        rd_rec,
   output logic [31:0]                             rd_id,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
   input  drt_pkg::wr_type                         wr
);

   drt_pkg::rec_type rec_mem [SLOTS];
   logic [31:0]      id_mem  [SLOTS];

   always_ff @(posedge clock) begin
      if (wr.rec_en) begin
         rec_mem[wr_addr] <= wr.rec;
      end
      if (wr.id_en) begin
         id_mem[wr_addr] <= wr.id;
      end
      rd_rec <= rec_mem[rd_addr];
      rd_id  <= id_mem[rd_addr];
   end

endmodule

FILE: tb/sv/tb_dedup_record_table.sv
// Testbench for the dedup record table: directed and random actions checked against a predictor.
`timescale 1ns / 1ps
module tb_dedup_record_table;

   localparam int N = 16;

   typedef struct packed {
      logic [2:0]   action;
      logic [255:0] key;
      logic [255:0] req;
      logic [31:0]  new_id;
   } op_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  kind;
      logic [31:0] id;
      logic [4:0]  nfree;
      logic [4:0]  npend;
      logic [4:0]  nfin;
      logic [4:0]  ncleared;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   drt_req_if req ();
   drt_rsp_if rsp ();

   dedup_record_table u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   // predictor copy of the table
   logic         tbl_valid [N];
   logic [255:0] tbl_key [N];
   logic [255:0] tbl_req [N];
   logic [31:0]  tbl_seq [N];
   logic [31:0]  tbl_id [N];

   answer_type answer_q[$];
   int errors = 0;
   int sent = 0;
   int checked = 0;
   int send_idle = 0;
   int recv_idle = 0;
   logic [255:0] key_pool [8];
   logic [255:0] req_pool [4];

   initial forever #5 clock = ~clock;

   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

   function automatic answer_type predict_answer(op_type op);
      answer_type a;
      int hit, empty, oldest, c;
      logic [31:0] oldest_seq, max_seq;
      a = '0;
      hit = -1;
      for (int i = N - 1; i >= 0; i--)
         if (tbl_valid[i] && tbl_key[i] == op.key) hit = i;
      case (op.action)
         drt_pkg::ACT_LOOKUP, drt_pkg::ACT_CLAIM: begin
            if (hit >= 0) begin
               a.id = tbl_id[hit];
               a.kind = (tbl_req[hit] == op.req) ? drt_pkg::KIND_REPLAY
                                                 : drt_pkg::KIND_CONFLICT;
            end else if (op.action == drt_pkg::ACT_CLAIM) begin
               empty = -1;
               oldest = -1;
               oldest_seq = drt_pkg::SEQ_MAX;
               max_seq = 0;
               for (int i = 0; i < N; i++) begin
                  if (!tbl_valid[i]) begin
                     if (empty < 0) empty = i;
                  end else begin
                     if (tbl_seq[i] > max_seq) max_seq = tbl_seq[i];
                     if (tbl_id[i] != 0 && tbl_seq[i] < oldest_seq) begin
                        oldest_seq = tbl_seq[i];
                        oldest = i;
                     end
                  end
               end
               if (empty < 0 && oldest < 0) a.status = drt_pkg::STS_NO_SPACE;
               else begin
                  c = (empty >= 0) ? empty : oldest;
                  tbl_valid[c] = 1'b1;
                  tbl_key[c] = op.key;
                  tbl_req[c] = op.req;
                  tbl_seq[c] = (max_seq == drt_pkg::SEQ_MAX) ? 32'd1 : max_seq + 32'd1;
                  tbl_id[c] = 0;
               end
            end
         end
         drt_pkg::ACT_FINALIZE: begin
            if (op.new_id == 0) a.status = drt_pkg::STS_BAD_ARG;
            else if (hit < 0) a.status = drt_pkg::STS_NOT_FOUND;
            else if (tbl_req[hit] != op.req) a.status = drt_pkg::STS_BAD_STATE;
            else tbl_id[hit] = op.new_id;
         end
         drt_pkg::ACT_RELEASE: begin
            if (hit < 0) a.status = drt_pkg::STS_NOT_FOUND;
            else if (tbl_req[hit] != op.req || tbl_id[hit] != 0)
               a.status = drt_pkg::STS_BAD_STATE;
            else tbl_valid[hit] = 1'b0;
         end
         drt_pkg::ACT_CLEAR: begin
            for (int i = 0; i < N; i++)
               if (tbl_valid[i] && tbl_id[i] == 0) begin
                  tbl_valid[i] = 1'b0;
                  a.ncleared++;
               end
         end
         drt_pkg::ACT_COUNT: begin
            for (int i = 0; i < N; i++)
               if (!tbl_valid[i]) a.nfree++;
               else if (tbl_id[i] == 0) a.npend++;
               else a.nfin++;
         end
         default: a.status = drt_pkg::STS_BAD_ARG;
      endcase
      return a;
   endfunction

   task automatic send_op(op_type op);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.action <= op.action;
      {req.key_hash_3, req.key_hash_2, req.key_hash_1, req.key_hash_0} <= op.key;
      {req.request_hash_3, req.request_hash_2, req.request_hash_1,
       req.request_hash_0} <= op.req;
      req.new_message_id <= op.new_id;
      do @(posedge clock); while (!req.ready);
      answer_q.push_back(predict_answer(op));
      sent++;
      @(negedge clock);
   endtask

   // receiver: random ready at falling edge, check at rising edge
   always @(negedge clock)
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      answer_type exp_a;
      if (!reset && rsp.valid && rsp.ready) begin
         if (answer_q.size() == 0) begin
            $error("result word with no expectation");
            errors++;
         end else begin
            exp_a = answer_q.pop_front();
            checked++;
            if (rsp.status !== exp_a.status) begin
               $error("status exp %0d got %0d", exp_a.status, rsp.status); errors++;
            end
            if (rsp.match_kind !== exp_a.kind) begin
               $error("match_kind exp %0d got %0d", exp_a.kind, rsp.match_kind); errors++;
            end
            if (rsp.found_message_id !== exp_a.id) begin
               $error("found_message_id exp %0h got %0h", exp_a.id, rsp.found_message_id);
               errors++;
            end
            if (rsp.free_count !== exp_a.nfree) begin
               $error("free_count exp %0d got %0d", exp_a.nfree, rsp.free_count); errors++;
            end
            if (rsp.pending_count !== exp_a.npend) begin
               $error("pending_count exp %0d got %0d", exp_a.npend, rsp.pending_count);
               errors++;
            end
            if (rsp.finalized_count !== exp_a.nfin) begin
               $error("finalized_count exp %0d got %0d", exp_a.nfin, rsp.finalized_count);
               errors++;
            end
            if (rsp.cleared_count !== exp_a.ncleared) begin
               $error("cleared_count exp %0d got %0d", exp_a.ncleared, rsp.cleared_count);
               errors++;
            end
         end
      end
   end

   function automatic logic [255:0] rand_wide();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic op_type make_op(logic [2:0] act, logic [255:0] k, logic [255:0] r,
                                      logic [31:0] id);
      op_type op;
      op.action = act;
      op.key = k;
      op.req = r;
      op.new_id = id;
      return op;
   endfunction

   task automatic test_directed();
      logic [255:0] ones;
      ones = '1;
      send_op(make_op(drt_pkg::ACT_COUNT, 0, 0, 0));
      send_op(make_op(drt_pkg::ACT_LOOKUP, 0, 0, 0));
      send_op(make_op(drt_pkg::ACT_CLAIM, 0, 0, 0));
      send_op(make_op(drt_pkg::ACT_CLAIM, 0, ones, 0));
      send_op(make_op(drt_pkg::ACT_FINALIZE, 0, 0, 0));
      send_op(make_op(drt_pkg::ACT_FINALIZE, ones, 0, 5));
      send_op(make_op(drt_pkg::ACT_FINALIZE, 0, ones, 5));
      send_op(make_op(drt_pkg::ACT_RELEASE, ones, ones, 0));
      send_op(make_op(drt_pkg::ACT_CLAIM, ones, ones, 0));
      send_op(make_op(drt_pkg::ACT_RELEASE, ones, 0, 0));
      send_op(make_op(drt_pkg::ACT_RELEASE, ones, ones, 0));
      send_op(make_op(drt_pkg::ACT_FINALIZE, 0, 0, 32'hFFFF_FFFF));
      send_op(make_op(drt_pkg::ACT_RELEASE, 0, 0, 0));
      send_op(make_op(drt_pkg::ACT_LOOKUP, 0, ones, 0));
      // fill the table to force eviction
      for (int i = 0; i < 16; i++)
         send_op(make_op(drt_pkg::ACT_CLAIM, 256'(i + 100), 0, 0));
      send_op(make_op(drt_pkg::ACT_COUNT, 0, 0, 0));
      send_op(make_op(drt_pkg::ACT_CLEAR, 0, 0, 0));
      send_op(make_op(drt_pkg::ACT_CLAIM, ones, 0, 0));
      send_op(make_op(3'd6, 0, 0, 0));
      send_op(make_op(3'd7, ones, ones, 32'hFFFF_FFFF));
   endtask

   task automatic test_random(int count);
      op_type op;
      int sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         op.key = (sel < 85) ? key_pool[$urandom_range(7)] : rand_wide();
         op.req = (sel < 80 || sel >= 95) ? req_pool[$urandom_range(3)] : rand_wide();
         op.new_id = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
         sel = $urandom_range(99);
         if (sel < 30) op.action = drt_pkg::ACT_CLAIM;
         else if (sel < 50) op.action = drt_pkg::ACT_FINALIZE;
         else if (sel < 65) op.action = drt_pkg::ACT_LOOKUP;
         else if (sel < 80) op.action = drt_pkg::ACT_RELEASE;
         else if (sel < 86) op.action = drt_pkg::ACT_CLEAR;
         else if (sel < 96) op.action = drt_pkg::ACT_COUNT;
         else op.action = 3'($urandom_range(7));
         send_op(op);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (N + 8) @(posedge clock);
   endtask

   initial begin
      req.valid = 1'b0;
      req.action = '0;
      {req.key_hash_3, req.key_hash_2, req.key_hash_1, req.key_hash_0} = '0;
      {req.request_hash_3, req.request_hash_2, req.request_hash_1,
       req.request_hash_0} = '0;
      req.new_message_id = '0;
      rsp.ready = 1'b0;
      for (int i = 0; i < N; i++) tbl_valid[i] = 1'b0;
      // small key pool for frequent hits; fresh random keys fill the table
      for (int i = 0; i < 8; i++) key_pool[i] = rand_wide();
      for (int i = 0; i < 4; i++) req_pool[i] = rand_wide();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 9;
      recv_idle = 47;
      test_directed();
      test_random(100);
      for (int i = 0; i < 8; i++) key_pool[i] = rand_wide();
      for (int ph = 0; ph < 6; ph++) begin
         // swap one pool key for a fresh one each phase so eviction and no-space can happen
         key_pool[$urandom_range(7)] = rand_wide();
         test_random(40);
      end
      send_idle = 47;
      recv_idle = 9;
      test_random(250);
      send_idle = 0;
      recv_idle = 0;
      test_random(200);
      drain();
      $display("sent %0d actions, checked %0d results under three idling patterns",
               sent, checked);
      if (errors == 0 && answer_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

FILE: files.f
design/drt_pkg.sv
design/drt_if.sv
design/drt_store.sv
design/dedup_record_table.sv
tb/sv/tb_dedup_record_table.sv
